// ===== design/assert_macros.svh =====
// Assertion macros for the design files; the TLV frame field extractor includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define TLVFX_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TLVFX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/tlvfx_pkg.sv =====
// Types and constants of the TLV frame field extractor.
package tlvfx_pkg;

	localparam int FIELD_COUNT = 5;
	localparam int IDX_W       = 3;

	typedef logic [15:0] type_code_t;
	typedef logic [2:0]  status_t;

	// field slots, in register order
	localparam int FLD_CAP   = 0;
	localparam int FLD_VLAN  = 1;
	localparam int FLD_DUPLEX = 2;
	localparam int FLD_TRUST = 3;
	localparam int FLD_COS   = 4;

	localparam logic [IDX_W-1:0] REG_LIMIT = 3'd5;

	localparam status_t ST_OK          = 3'd0;
	localparam status_t ST_FRAME_SHORT = 3'd1;
	localparam status_t ST_PARTIAL_HDR = 3'd2;
	localparam status_t ST_LEN_OVER    = 3'd3;
	localparam status_t ST_LEN_SHORT   = 3'd4;

	localparam logic [15:0] HEADER_BYTES = 16'd4;
	localparam logic [2:0]  FRAME_MIN    = 3'd4;

	localparam type_code_t TYPE_RESET [FIELD_COUNT] = '{16'd4, 16'd10, 16'd11, 16'd18, 16'd19};
	localparam logic [15:0] BYTES_NEEDED [FIELD_COUNT] = '{16'd8, 16'd6, 16'd5, 16'd5, 16'd5};

endpackage

// ===== design/tlv_frame_field_extractor.sv =====
// TLV frame field extractor: walks a TLV chain byte by byte and reports fields per frame.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------------
//  in      | in_valid / in_stall  | data_byte, last_byte
//  out     | out_valid / out_stall| capabilities, native_vlan, duplex, trust_bitmap,
//          |                      | untrusted_cos, tlv_count, status
//  cfg     | cfg_we               | cfg_index, cfg_data
//
// One byte per cycle while in_stall is low; the result of a frame appears in the cycle after its last byte is accepted.
// Walk state updates in the accept cycle; the result sits in an output register.
// A stalled result holds the input off only while it is still waiting.
// Reset loads the default type codes and clears the frame state and out_valid.
module tlv_frame_field_extractor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] capabilities,
	output logic [15:0] native_vlan,
	output logic [7:0]  duplex,
	output logic [7:0]  trust_bitmap,
	output logic [7:0]  untrusted_cos,
	output logic [7:0]  tlv_count,
	output logic [2:0]  status,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	`include "assert_macros.svh"

	localparam int NF = tlvfx_pkg::FIELD_COUNT;

	tlvfx_pkg::type_code_t type_q [NF];

	logic [15:0] pos_q, pos_n;
	logic [15:0] ctype_q, ctype_n;
	logic [15:0] clen_q, clen_n;
	logic [2:0]  seen_q, seen_n;
	logic [31:0] cap_q, cap_n;
	logic [15:0] vlan_q, vlan_n;
	logic [7:0]  dup_q, dup_n;
	logic [7:0]  trust_q, trust_n;
	logic [7:0]  cos_q, cos_n;
	logic [NF-1:0] found_q, found_n;
	logic [7:0]  count_q, count_n;
	tlvfx_pkg::status_t err_q, err_n;

	logic [NF-1:0] act;
	logic [NF-1:0] short_clr;
	logic          finish;
	logic [15:0]   len_full;
	logic          in_value_window;
	tlvfx_pkg::status_t st_n;
	logic          ok_n;

	logic        out_valid_q;
	logic [31:0] cap_out_q;
	logic [15:0] vlan_out_q;
	logic [7:0]  dup_out_q, trust_out_q, cos_out_q, count_out_q;
	tlvfx_pkg::status_t st_out_q;

	logic accept;

	assign in_stall = out_valid_q & out_stall;
	assign accept   = in_valid & ~in_stall;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NF; k++) type_q[k] <= tlvfx_pkg::TYPE_RESET[k];
		end else if (cfg_we && cfg_index < tlvfx_pkg::REG_LIMIT) begin
			type_q[cfg_index] <= cfg_data;
		end
	end

	always_comb begin
		for (int k = 0; k < NF; k++) begin
			act[k] = ~found_q[k] && (type_q[k] == ctype_q);
		end
	end

	assign len_full        = {clen_q[15:8], data_byte};
	assign in_value_window = (pos_q[15:2] == 14'd1);

	// next walk state for the byte on the input
	always_comb begin
		pos_n     = pos_q;
		ctype_n   = ctype_q;
		clen_n    = clen_q;
		cap_n     = cap_q;
		vlan_n    = vlan_q;
		dup_n     = dup_q;
		trust_n   = trust_q;
		cos_n     = cos_q;
		found_n   = found_q;
		count_n   = count_q;
		err_n     = err_q;
		finish    = 1'b0;
		short_clr = '0;
		seen_n    = (seen_q < tlvfx_pkg::FRAME_MIN) ? seen_q + 3'd1 : seen_q;

		if (err_q == tlvfx_pkg::ST_OK) begin
			case (pos_q)
				16'd0: begin
					ctype_n = {data_byte, 8'h00};
					pos_n   = 16'd1;
				end
				16'd1: begin
					ctype_n = {ctype_q[15:8], data_byte};
					pos_n   = 16'd2;
				end
				16'd2: begin
					clen_n = {data_byte, 8'h00};
					pos_n  = 16'd3;
				end
				16'd3: begin
					clen_n = len_full;
					if (len_full < tlvfx_pkg::HEADER_BYTES) begin
						err_n = tlvfx_pkg::ST_LEN_SHORT;
					end else if (len_full == tlvfx_pkg::HEADER_BYTES) begin
						finish = 1'b1;
					end else begin
						pos_n = 16'd4;
					end
				end
				default: begin
					if (in_value_window) begin
						if (act[tlvfx_pkg::FLD_CAP]) begin
							case (pos_q[1:0])
								2'd0: cap_n[31:24] = data_byte;
								2'd1: cap_n[23:16] = data_byte;
								2'd2: cap_n[15:8]  = data_byte;
								default: cap_n[7:0] = data_byte;
							endcase
						end
						if (pos_q[1:0] == 2'd0) begin
							if (act[tlvfx_pkg::FLD_VLAN])   vlan_n[15:8] = data_byte;
							if (act[tlvfx_pkg::FLD_DUPLEX]) dup_n = data_byte;
							if (act[tlvfx_pkg::FLD_TRUST])  trust_n = data_byte;
							if (act[tlvfx_pkg::FLD_COS])    cos_n = data_byte;
						end else if (pos_q[1:0] == 2'd1) begin
							if (act[tlvfx_pkg::FLD_VLAN])   vlan_n[7:0] = data_byte;
						end
					end
					if (({1'b0, pos_q} + 17'd1) >= {1'b0, clen_q}) begin
						finish = 1'b1;
					end else begin
						pos_n = pos_q + 16'd1;
					end
				end
			endcase
		end

		// close the TLV: mark first hits, drop fields the TLV was too short for
		if (finish) begin
			for (int k = 0; k < NF; k++) begin
				if (act[k]) begin
					found_n[k]   = 1'b1;
					short_clr[k] = (clen_n < tlvfx_pkg::BYTES_NEEDED[k]);
				end
			end
			if (count_q != 8'hFF) count_n = count_q + 8'd1;
			pos_n = 16'd0;
		end
		if (short_clr[tlvfx_pkg::FLD_CAP])    cap_n = '0;
		if (short_clr[tlvfx_pkg::FLD_VLAN])   vlan_n = '0;
		if (short_clr[tlvfx_pkg::FLD_DUPLEX]) dup_n = '0;
		if (short_clr[tlvfx_pkg::FLD_TRUST])  trust_n = '0;
		if (short_clr[tlvfx_pkg::FLD_COS])    cos_n = '0;
	end

	always_comb begin
		if (seen_n < tlvfx_pkg::FRAME_MIN) begin
			st_n = tlvfx_pkg::ST_FRAME_SHORT;
		end else if (err_n != tlvfx_pkg::ST_OK) begin
			st_n = err_n;
		end else if (pos_n != 16'd0 && pos_n < tlvfx_pkg::HEADER_BYTES) begin
			st_n = tlvfx_pkg::ST_PARTIAL_HDR;
		end else if (pos_n >= tlvfx_pkg::HEADER_BYTES) begin
			st_n = tlvfx_pkg::ST_LEN_OVER;
		end else begin
			st_n = tlvfx_pkg::ST_OK;
		end
	end

	assign ok_n = (st_n == tlvfx_pkg::ST_OK);

	// frame state: advance on each beat, clear after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			ctype_q <= '0;
			clen_q  <= '0;
			seen_q  <= '0;
			cap_q   <= '0;
			vlan_q  <= '0;
			dup_q   <= '0;
			trust_q <= '0;
			cos_q   <= '0;
			found_q <= '0;
			count_q <= '0;
			err_q   <= tlvfx_pkg::ST_OK;
		end else if (accept) begin
			if (last_byte) begin
				pos_q   <= '0;
				ctype_q <= '0;
				clen_q  <= '0;
				seen_q  <= '0;
				cap_q   <= '0;
				vlan_q  <= '0;
				dup_q   <= '0;
				trust_q <= '0;
				cos_q   <= '0;
				found_q <= '0;
				count_q <= '0;
				err_q   <= tlvfx_pkg::ST_OK;
			end else begin
				pos_q   <= pos_n;
				ctype_q <= ctype_n;
				clen_q  <= clen_n;
				seen_q  <= seen_n;
				cap_q   <= cap_n;
				vlan_q  <= vlan_n;
				dup_q   <= dup_n;
				trust_q <= trust_n;
				cos_q   <= cos_n;
				found_q <= found_n;
				count_q <= count_n;
				err_q   <= err_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && last_byte) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last_byte) begin
			cap_out_q   <= (ok_n && found_n[tlvfx_pkg::FLD_CAP])    ? cap_n   : '0;
			vlan_out_q  <= (ok_n && found_n[tlvfx_pkg::FLD_VLAN])   ? vlan_n  : '0;
			dup_out_q   <= (ok_n && found_n[tlvfx_pkg::FLD_DUPLEX]) ? dup_n   : '0;
			trust_out_q <= (ok_n && found_n[tlvfx_pkg::FLD_TRUST])  ? trust_n : '0;
			cos_out_q   <= (ok_n && found_n[tlvfx_pkg::FLD_COS])    ? cos_n   : '0;
			count_out_q <= count_n;
			st_out_q    <= st_n;
		end
	end

	assign out_valid     = out_valid_q;
	assign capabilities  = cap_out_q;
	assign native_vlan   = vlan_out_q;
	assign duplex        = dup_out_q;
	assign trust_bitmap  = trust_out_q;
	assign untrusted_cos = cos_out_q;
	assign tlv_count     = count_out_q;
	assign status        = st_out_q;

	`TLVFX_ASSERT_NEXT(a_last_gives_result, clk, arst_n, accept && last_byte, out_valid_q, "last beat did not produce a result")
	`TLVFX_ASSERT_NEXT(a_frame_cleared, clk, arst_n, accept && last_byte, seen_q == 3'd0 && found_q == '0 && pos_q == 16'd0, "frame state not cleared after last beat")
	`TLVFX_ASSERT(a_error_zeroes_fields, clk, arst_n, !out_valid_q || st_out_q == tlvfx_pkg::ST_OK || (cap_out_q == '0 && vlan_out_q == '0 && dup_out_q == '0 && trust_out_q == '0 && cos_out_q == '0), "fields nonzero with error status")
	`TLVFX_ASSERT(a_err_code_kind, clk, arst_n, err_q == tlvfx_pkg::ST_OK || err_q == tlvfx_pkg::ST_LEN_SHORT, "unexpected walk error code")

endmodule

// ===== verif/tlv_report_checker.sv =====
// Frame report checker for the TLV frame field extractor: tracks the TLV walk and compares reports.
module tlv_report_checker
	import tlvfx_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [31:0] capabilities,
	input  logic [15:0] native_vlan,
	input  logic [7:0]  duplex,
	input  logic [7:0]  trust_bitmap,
	input  logic [7:0]  untrusted_cos,
	input  logic [7:0]  tlv_count,
	input  logic [2:0]  status,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          fail_count,
	output int          reports_checked,
	output int          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [31:0] cap;
		logic [15:0] vlan;
		logic [7:0]  duplex;
		logic [7:0]  trust;
		logic [7:0]  cos;
		logic [7:0]  count;
		status_t     status;
	} frame_report_t;

	type_code_t    field_type [FIELD_COUNT];
	logic [15:0]   tlv_pos;
	logic [15:0]   cur_type;
	logic [15:0]   cur_len;
	logic [2:0]    bytes_seen;
	logic [31:0]   cap_q;
	logic [15:0]   vlan_q;
	logic [7:0]    duplex_q;
	logic [7:0]    trust_q;
	logic [7:0]    cos_q;
	logic [4:0]    found;
	logic [7:0]    tlv_total;
	status_t       walk_err;
	frame_report_t reports_due [$];

	function automatic string show(frame_report_t r);
		return $sformatf("cap=%h vlan=%h duplex=%h trust=%h cos=%h count=%0d status=%0d",
			r.cap, r.vlan, r.duplex, r.trust, r.cos, r.count, r.status);
	endfunction

	function automatic void clear_frame_state();
		tlv_pos    = '0;
		cur_type   = '0;
		cur_len    = '0;
		bytes_seen = '0;
		cap_q      = '0;
		vlan_q     = '0;
		duplex_q   = '0;
		trust_q    = '0;
		cos_q      = '0;
		found      = '0;
		tlv_total  = '0;
		walk_err   = ST_OK;
	endfunction

	// only the first TLV of each configured type feeds its field
	function automatic bit field_live(int k);
		return !found[k] && field_type[k] == cur_type;
	endfunction

	function automatic void close_tlv();
		int k;
		logic [15:0] need;
		for (k = 0; k < FIELD_COUNT; k++) begin
			need = (k == FLD_CAP) ? 16'd8 : (k == FLD_VLAN) ? 16'd6 : 16'd5;
			if (field_live(k)) begin
				// drop a capture whose TLV is too short to hold the field
				if (cur_len < need) begin
					case (k)
						FLD_CAP:    cap_q = '0;
						FLD_VLAN:   vlan_q = '0;
						FLD_DUPLEX: duplex_q = '0;
						FLD_TRUST:  trust_q = '0;
						default:    cos_q = '0;
					endcase
				end
				found[k] = 1'b1;
			end
		end
		if (tlv_total != 8'hFF)
			tlv_total++;
		tlv_pos = '0;
	endfunction

	function automatic void walk_byte(input logic [7:0] b, input logic fin,
			output frame_report_t rpt, output bit done);
		logic [15:0] pos;
		status_t     st;
		bit          clean;
		pos  = tlv_pos;
		done = 1'b0;
		rpt  = '0;
		if (bytes_seen < 3'd4)
			bytes_seen++;
		if (walk_err == ST_OK) begin
			case (pos)
				16'd0: begin
					cur_type = {b, 8'h00};
					tlv_pos = 16'd1;
				end
				16'd1: begin
					cur_type[7:0] = b;
					tlv_pos = 16'd2;
				end
				16'd2: begin
					cur_len = {b, 8'h00};
					tlv_pos = 16'd3;
				end
				16'd3: begin
					cur_len[7:0] = b;
					if (cur_len < 16'd4)
						walk_err = ST_LEN_SHORT;
					else if (cur_len == 16'd4)
						close_tlv();
					else
						tlv_pos = 16'd4;
				end
				default: begin
					case (pos)
						16'd4: begin
							if (field_live(FLD_CAP))    cap_q[31:24] = b;
							if (field_live(FLD_VLAN))   vlan_q[15:8] = b;
							if (field_live(FLD_DUPLEX)) duplex_q = b;
							if (field_live(FLD_TRUST))  trust_q = b;
							if (field_live(FLD_COS))    cos_q = b;
						end
						16'd5: begin
							if (field_live(FLD_CAP))  cap_q[23:16] = b;
							if (field_live(FLD_VLAN)) vlan_q[7:0] = b;
						end
						16'd6: if (field_live(FLD_CAP)) cap_q[15:8] = b;
						16'd7: if (field_live(FLD_CAP)) cap_q[7:0] = b;
						default: ;
					endcase
					if ({1'b0, pos} + 17'd1 >= {1'b0, cur_len})
						close_tlv();
					else
						tlv_pos = pos + 16'd1;
				end
			endcase
		end
		if (fin) begin
			if (bytes_seen < 3'd4)
				st = ST_FRAME_SHORT;
			else if (walk_err != ST_OK)
				st = walk_err;
			else if (tlv_pos >= 16'd1 && tlv_pos < 16'd4)
				st = ST_PARTIAL_HDR;
			else if (tlv_pos >= 16'd4)
				st = ST_LEN_OVER;
			else
				st = ST_OK;
			clean      = (st == ST_OK);
			rpt.cap    = (clean && found[FLD_CAP])    ? cap_q    : '0;
			rpt.vlan   = (clean && found[FLD_VLAN])   ? vlan_q   : '0;
			rpt.duplex = (clean && found[FLD_DUPLEX]) ? duplex_q : '0;
			rpt.trust  = (clean && found[FLD_TRUST])  ? trust_q  : '0;
			rpt.cos    = (clean && found[FLD_COS])    ? cos_q    : '0;
			rpt.count  = tlv_total;
			rpt.status = st;
			done       = 1'b1;
			clear_frame_state();
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		frame_report_t seen, want, made;
		bit produced;
		if (!arst_n) begin
			field_type[FLD_CAP]    = 16'd4;
			field_type[FLD_VLAN]   = 16'd10;
			field_type[FLD_DUPLEX] = 16'd11;
			field_type[FLD_TRUST]  = 16'd18;
			field_type[FLD_COS]    = 16'd19;
			clear_frame_state();
			reports_due.delete();
			fail_count      = 0;
			reports_checked = 0;
		end else begin
			if (out_valid && !out_stall) begin
				seen = {capabilities, native_vlan, duplex, trust_bitmap, untrusted_cos,
					tlv_count, status};
				if (reports_due.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected report: %s", show(seen));
				end else begin
					want = reports_due.pop_front();
					reports_checked++;
					if (seen !== want) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("mismatch on report %0d", reports_checked);
							$display("  want %s", show(want));
							$display("  got  %s", show(seen));
						end
					end
				end
			end
			// indexes past the last register are dropped
			if (cfg_we && cfg_index < REG_LIMIT)
				field_type[cfg_index] = cfg_data;
			if (in_valid && !in_stall) begin
				walk_byte(data_byte, last_byte, made, produced);
				if (produced)
					reports_due = {reports_due, made};
			end
		end
		outstanding = reports_due.size();
	end

endmodule

// ===== verif/tlv_frame_field_extractor_tb.sv =====
// Testbench top for the TLV frame field extractor: frame stimulus, stalls and verdict.
module tlv_frame_field_extractor_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tlvfx_pkg::*;

	localparam int CYCLE_LIMIT = 800000;
	localparam int PHASE_BYTES = 95;
	localparam logic [79:0] DEFAULT_KINDS = {16'd19, 16'd18, 16'd11, 16'd10, 16'd4};

	typedef logic [7:0] frame_bytes_t [$];

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        last_byte;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] capabilities;
	logic [15:0] native_vlan;
	logic [7:0]  duplex;
	logic [7:0]  trust_bitmap;
	logic [7:0]  untrusted_cos;
	logic [7:0]  tlv_count;
	logic [2:0]  status;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	int fail_count;
	int reports_checked;
	int outstanding;

	logic [79:0] kinds_now;
	int          in_calm;
	int          out_calm;
	int          frames_sent;
	int          bytes_sent;
	int          settings_used;
	int          cycles;

	tlv_frame_field_extractor u_top (.*);

	tlv_report_checker u_check (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles", cycles);
		$display("tb: failure");
		$finish;
	end

	// mostly short gaps, a few long ones, and now and then a calm stretch with none
	function automatic int idle_len(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm = $urandom_range(20, 80);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 2);
		if (r < 97)
			return $urandom_range(3, 8);
		return $urandom_range(12, 40);
	endfunction

	initial begin
		int  hold;
		bit  stall_now;
		out_stall = 1'b0;
		out_calm  = 0;
		hold      = 0;
		stall_now = 1'b0;
		forever @(posedge clk) begin
			if (hold > 0) begin
				hold--;
			end else if (stall_now) begin
				stall_now = 1'b0;
				hold = $urandom_range(0, 8);
			end else begin
				hold = idle_len(out_calm);
				stall_now = (hold > 0);
				if (stall_now)
					hold--;
			end
			out_stall <= stall_now;
		end
	end

	function automatic logic [15:0] pick_kind();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return kinds_now[$urandom_range(0, FIELD_COUNT - 1) * 16 +: 16];
		if (r < 80)
			return 16'h0000;
		if (r < 85)
			return 16'hFFFF;
		return 16'($urandom_range(0, 65535));
	endfunction

	function automatic logic [15:0] pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return 16'd4;
		if (r < 75)
			return 16'($urandom_range(5, 9));
		if (r < 95)
			return 16'($urandom_range(10, 24));
		return 16'($urandom_range(25, 60));
	endfunction

	// emit the first keep bytes of a TLV; value bytes are random
	task automatic add_tlv(inout frame_bytes_t f, input logic [15:0] kind,
			input logic [15:0] len, input int keep);
		int         i;
		logic [7:0] b;
		for (i = 0; i < keep; i++) begin
			case (i)
				0:       b = kind[15:8];
				1:       b = kind[7:0];
				2:       b = len[15:8];
				3:       b = len[7:0];
				default: b = 8'($urandom_range(0, 255));
			endcase
			f = {f, b};
		end
	endtask

	task automatic build_frame(output frame_bytes_t f);
		int          n;
		int          r;
		int          i;
		logic [15:0] len;
		f.delete();
		n = $urandom_range(1, 4);
		r = $urandom_range(0, 99);
		if (r < 10) begin
			repeat ($urandom_range(1, 24)) f = {f, 8'($urandom_range(0, 255))};
		end else if (r < 15) begin
			repeat ($urandom_range(1, 3)) f = {f, 8'($urandom_range(0, 255))};
		end else begin
			for (i = 1; i < n; i++) begin
				len = pick_len();
				add_tlv(f, pick_kind(), len, len);
			end
			if (r < 25) begin
				// end inside a header
				add_tlv(f, pick_kind(), pick_len(), $urandom_range(1, 3));
			end else if (r < 33) begin
				// bad length, then bytes the block must skip
				add_tlv(f, pick_kind(), 16'($urandom_range(0, 3)), 4);
				repeat ($urandom_range(0, 6)) f = {f, 8'($urandom_range(0, 255))};
			end else if (r < 45) begin
				// end inside a value
				len = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(61, 65535))
					: 16'($urandom_range(5, 40));
				add_tlv(f, pick_kind(), len, $urandom_range(4, (len > 40) ? 40 : len - 1));
			end else begin
				len = pick_len();
				add_tlv(f, pick_kind(), len, len);
			end
		end
	endtask

	task automatic send_frame(input frame_bytes_t f);
		int i;
		int gap;
		for (i = 0; i < f.size(); i++) begin
			gap = idle_len(in_calm);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			in_valid  <= 1'b1;
			data_byte <= f[i];
			last_byte <= (i == f.size() - 1);
			@(posedge clk);
			while (in_stall) @(posedge clk);
			bytes_sent++;
		end
		frames_sent++;
	endtask

	// let the checker catch up on pushes of the final edge, then settle the block
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		repeat (4) @(posedge clk);
	endtask

	// writes to the three unused indexes go along and must change nothing
	task automatic program_kinds(input logic [79:0] kinds);
		int idx;
		for (idx = 0; idx < 8; idx++) begin
			cfg_we    <= 1'b1;
			cfg_index <= 3'(idx);
			cfg_data  <= (idx < FIELD_COUNT) ? kinds[idx * 16 +: 16]
				: 16'($urandom_range(0, 65535));
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		kinds_now = kinds;
		settings_used++;
	endtask

	initial begin
		frame_bytes_t f;
		logic [79:0]  setting;
		logic [15:0]  ka;
		logic [15:0]  kb;
		int           p;
		int           i;
		int           phase_start;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		data_byte     = '0;
		last_byte     = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		kinds_now     = DEFAULT_KINDS;
		in_calm       = 0;
		frames_sent   = 0;
		bytes_sent    = 0;
		settings_used = 1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (p = 0; p < 6; p++) begin
			case (p)
				1: setting = '0;
				2: setting = '1;
				3: setting = 80'({$urandom, $urandom, $urandom});
				4: begin
					// two codes shared among the five fields
					ka = 16'($urandom_range(0, 65535));
					kb = 16'($urandom_range(0, 65535));
					for (i = 0; i < FIELD_COUNT; i++)
						setting[i * 16 +: 16] = $urandom_range(0, 1) ? ka : kb;
				end
				default: setting = DEFAULT_KINDS;
			endcase
			if (p != 0)
				program_kinds(setting);

			if (p == 0) begin
				// capabilities with all value bits set
				f = '{8'h00, 8'h04, 8'h00, 8'h08, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
				send_frame(f);
				// VLAN TLV too short, then a second VLAN TLV that must be ignored
				f = '{8'h00, 8'h0A, 8'h00, 8'h05, 8'h12,
					8'h00, 8'h0A, 8'h00, 8'h06, 8'hAB, 8'hCD};
				send_frame(f);
				// frame under four bytes
				f = '{8'h13};
				send_frame(f);
				// header-only TLV, then the frame stops inside the next header
				f = '{8'h00, 8'h13, 8'h00, 8'h04, 8'h00, 8'h12};
				send_frame(f);
				// length under four
				f = '{8'h00, 8'h12, 8'h00, 8'h02};
				send_frame(f);
				// length past the end of the frame
				f = '{8'h00, 8'h12, 8'hFF, 8'hFF, 8'h01};
				send_frame(f);
			end
			if (p == 5) begin
				// drive the TLV count into saturation
				f.delete();
				repeat (257) add_tlv(f, pick_kind(), 16'd4, 4);
				send_frame(f);
			end

			phase_start = bytes_sent;
			while (bytes_sent - phase_start < PHASE_BYTES) begin
				build_frame(f);
				send_frame(f);
			end
			drain();
		end

		$display("sent %0d frames, %0d bytes under %0d type settings",
			frames_sent, bytes_sent, settings_used);
		$display("cut, bad-length, short and saturating frames; %0d reports, %0d mismatches",
			reports_checked, fail_count);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
